### rtl/command_retry_queue_top_assert.svh
// Assertion macros used by the queue RTL.
`ifndef COMMAND_RETRY_QUEUE_TOP_ASSERT_SVH
`define COMMAND_RETRY_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define CRQ_ASSERT_IMPLY(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define CRQ_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/crq_pkg.sv
`default_nettype none

package crq_pkg;

  // Default ring depth.
  localparam int SLOTS_DEF = 8;

  // Configuration port address width: three registers at byte offsets 0, 4 and 8.
  localparam int CFG_AW = 4;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_RETRY   = 2'd1;
  localparam logic [1:0] REG_CONFIRM = 2'd2;

  // Register reset values.
  localparam logic [31:0] TIMEOUT_RST = 32'd1000;
  localparam logic [3:0]  RETRY_RST   = 4'd3;
  localparam logic [15:0] CONFIRM_RST = 16'h0100;

  // Action codes of an input word.
  typedef enum logic [1:0] {
    ACT_INSERT   = 2'd0,
    ACT_RESPONSE = 2'd1,
    ACT_POLL     = 2'd2
  } action_t;

  // Slot status codes.
  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_SCHED = 2'd1,
    ST_SENT  = 2'd2
  } slot_st_t;

  // Input word.
  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] cmd_word;
    logic [31:0] now_time;
  } in_item_t;

  // Result word.
  typedef struct packed {
    logic        send_now;
    logic [15:0] send_command;
    logic [2:0]  send_slot;
    logic        is_resend;
    logic        response_ok;
    logic        error_flag;
  } out_item_t;

  // Configuration as seen by the queue.
  typedef struct packed {
    logic [31:0] timeout_ticks;
    logic [3:0]  retry_limit;
    logic [15:0] confirm_mask;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/crq_cfg_regs.sv
`default_nettype none

module crq_cfg_regs
  import crq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic [31:0] timeout_r;
  logic [3:0]  retry_r;
  logic [15:0] confirm_r;
  logic        wr_en;
  logic [1:0]  reg_idx;

  // The port never inserts wait states.
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  // Register writes; an address beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      retry_r   <= RETRY_RST;
      confirm_r <= CONFIRM_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TIMEOUT: timeout_r <= pwdata;
        REG_RETRY:   retry_r   <= pwdata[3:0];
        REG_CONFIRM: confirm_r <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Read data.
  always_comb begin
    unique case (reg_idx)
      REG_TIMEOUT: prdata = timeout_r;
      REG_RETRY:   prdata = {28'd0, retry_r};
      REG_CONFIRM: prdata = {16'd0, confirm_r};
      default:     prdata = 32'd0;
    endcase
  end

  assign cfg.timeout_ticks = timeout_r;
  assign cfg.retry_limit   = retry_r;
  assign cfg.confirm_mask  = confirm_r;

endmodule

`default_nettype wire

### rtl/crq_slot_queue.sv
`default_nettype none

module crq_slot_queue
  import crq_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
)
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  input  wire logic      in_vld,
  input  wire in_item_t  in_item,
  output logic           out_vld,
  output out_item_t      out_word
);

`include "command_retry_queue_top_assert.svh"

  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  // Slot status is reset; the payload arrays are only read once written.
  slot_st_t          status_r   [SLOTS];
  slot_st_t          status_nxt [SLOTS];
  logic [15:0]       cmd_r      [SLOTS];
  logic [31:0]       start_r    [SLOTS];
  logic [4:0]        retries_r  [SLOTS];
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic              error_r, error_nxt;
  logic              out_vld_r;
  out_item_t         out_r, res;

  logic [IDX_W-1:0]  head_inc, tail_inc;
  logic [IDX_W+2:0]  head_ext;
  logic [31:0]       due;
  logic [4:0]        retries_new;
  logic              ins_we, poll_we, clear_q;
  logic [SLOTS-1:0]  occ;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
    wrap_inc = (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
  endfunction

  assign head_inc = wrap_inc(head_r);
  assign tail_inc = wrap_inc(tail_r);
  assign head_ext = (IDX_W + 3)'(head_r);
  assign due      = start_r[head_r] + cfg.timeout_ticks;

  // Occupancy map of the ring.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      occ[i] = (status_r[i] != ST_EMPTY);
    end
  end

  // Next state and result of the word held in the input register.
  always_comb begin
    status_nxt  = status_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    error_nxt   = error_r;
    ins_we      = 1'b0;
    poll_we     = 1'b0;
    clear_q     = 1'b0;
    retries_new = '0;
    res         = '0;

    if (in_vld) begin
      unique case (in_item.action)
        ACT_INSERT: begin
          if (status_r[tail_r] != ST_EMPTY) begin
            clear_q   = 1'b1;
            error_nxt = 1'b1;
          end else begin
            error_nxt          = 1'b0;
            status_nxt[tail_r] = ST_SCHED;
            ins_we             = 1'b1;
            tail_nxt           = tail_inc;
          end
        end
        ACT_RESPONSE: begin
          if (status_r[head_r] != ST_EMPTY &&
              in_item.cmd_word == (cmd_r[head_r] | cfg.confirm_mask)) begin
            res.response_ok    = 1'b1;
            status_nxt[head_r] = ST_EMPTY;
            head_nxt           = head_inc;
            // The ring has drained once the following slot is empty.
            if (status_r[head_inc] == ST_EMPTY) begin
              clear_q = 1'b1;
            end
          end
        end
        ACT_POLL: begin
          if (status_r[head_r] == ST_SCHED) begin
            // First transmission of the head command.
            poll_we            = 1'b1;
            retries_new        = '0;
            status_nxt[head_r] = ST_SENT;
            res.send_now       = 1'b1;
            res.send_command   = cmd_r[head_r];
            res.send_slot      = head_ext[2:0];
          end else if (status_r[head_r] == ST_SENT) begin
            if (in_item.now_time > due) begin
              if (retries_r[head_r] > {1'b0, cfg.retry_limit}) begin
                // Retries exhausted: give up on the whole ring.
                clear_q   = 1'b1;
                error_nxt = 1'b1;
              end else begin
                poll_we          = 1'b1;
                retries_new      = retries_r[head_r] + 5'd1;
                res.send_now     = 1'b1;
                res.send_command = cmd_r[head_r];
                res.send_slot    = head_ext[2:0];
                res.is_resend    = 1'b1;
              end
            end
          end else if (head_r == tail_r && head_r != '0) begin
            clear_q = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    // Queue reset empties every slot and rewinds both pointers.
    if (clear_q) begin
      for (int i = 0; i < SLOTS; i++) begin
        status_nxt[i] = ST_EMPTY;
      end
      head_nxt = '0;
      tail_nxt = '0;
    end

    res.error_flag = error_nxt;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        status_r[i] <= ST_EMPTY;
      end
      head_r    <= '0;
      tail_r    <= '0;
      error_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      status_r  <= status_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      error_r   <= error_nxt;
      out_vld_r <= in_vld;
    end
  end

  // Slot payload and result register.
  always_ff @(posedge clk) begin
    if (ins_we) begin
      cmd_r[tail_r]     <= in_item.cmd_word;
      start_r[tail_r]   <= '0;
      retries_r[tail_r] <= '0;
    end
    if (poll_we) begin
      start_r[head_r]   <= in_item.now_time;
      retries_r[head_r] <= retries_new;
    end
    out_r <= res;
  end

  assign out_vld  = out_vld_r;
  assign out_word = out_r;

  // A resend is always a transmission.
  `CRQ_ASSERT_IMPLY(a_resend_sends, clk, rst_n, out_vld_r && out_r.is_resend,
                    out_r.send_now, "resend without send")
  // A response and a transmission never come from the same word.
  `CRQ_ASSERT_IMPLY(a_ok_no_send, clk, rst_n, out_vld_r && out_r.response_ok,
                    !out_r.send_now, "send on response")
  // The ring is contiguous from the head: an empty head means an empty ring.
  `CRQ_ASSERT_IMPLY(a_head_empty, clk, rst_n, !occ[head_r], occ == '0,
                    "occupied slot behind empty head")
  // Error is only raised together with a queue reset and cleared by a good insert.
  `CRQ_ASSERT_IMPLY(a_err_empty, clk, rst_n, occ != '0, !error_r,
                    "error set with commands queued")
  // A good insert leaves the ring occupied.
  `CRQ_ASSERT_NEXT(a_insert_fills, clk, rst_n, in_vld && ins_we, occ != '0,
                   "insert lost")

endmodule

`default_nettype wire

### rtl/command_retry_queue_top.sv
// Command retry queue: a word is taken at every clock edge where start is high.
// The word passes the input register, then the queue update and the result register;
// throughput one word per cycle, busy stays low.
// The result is shown for one cycle only, as the receiver cannot stall.
// Synchronous reset empties all slots, rewinds head and tail to 0, clears the error
// bit and restores the register defaults; no clearing pass is needed.
`default_nettype none

module command_retry_queue_top
  import crq_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
)
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire in_item_t          in_word,
  output logic                   out_strobe,
  output out_item_t              out_word,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  cfg_t     cfg;
  logic     in_vld_r;
  in_item_t in_item_r;

  // Every word is handled in a single pass, so the queue never holds off.
  assign busy = 1'b0;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_item_r <= in_word;
    end
  end

  crq_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  crq_slot_queue #(
    .SLOTS (SLOTS)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_vld   (in_vld_r),
    .in_item  (in_item_r),
    .out_vld  (out_strobe),
    .out_word (out_word)
  );

endmodule

`default_nettype wire

### tb/tb_command_retry_queue_top.sv
`default_nettype none

module tb_command_retry_queue_top;
  import crq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING = SLOTS_DEF;
  localparam int IW = $clog2(RING);
  localparam int QUIET_LIMIT = 2000;

  // Action code that the block leaves without effect.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Two copies of the ring state: one follows the words the block has taken,
  // the other runs ahead while stimulus is planned.
  localparam int ACCEPTED_VIEW = 0;
  localparam int PLANNED_VIEW = 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_word = '0;
  logic out_strobe;
  out_item_t out_word;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  command_retry_queue_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial forever #4 clk = ~clk;

  // Register values as the block should hold them.
  logic [31:0] cfg_timeout = TIMEOUT_RST;
  logic [3:0] cfg_retry = RETRY_RST;
  logic [15:0] cfg_confirm = CONFIRM_RST;

  // Ring state, one copy per view.
  slot_st_t q_status [2][RING];
  logic [15:0] q_cmd [2][RING];
  logic [31:0] q_start [2][RING];
  logic [4:0] q_retries [2][RING];
  logic [IW-1:0] q_head [2];
  logic [IW-1:0] q_tail [2];
  logic q_err [2];

  in_item_t pending_words[$];
  out_item_t predicted_results[$];
  int unsigned items_planned = 0;
  int unsigned items_taken = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  logic steady_feed = 1'b0;
  logic [31:0] poll_clock = '0;

  function automatic logic [IW-1:0] ring_next(logic [IW-1:0] i);
    return (int'(i) + 1 >= RING) ? '0 : i + IW'(1);
  endfunction

  // Empties every slot and rewinds both indexes; the error bit is untouched.
  function automatic void clear_ring(int k);
    for (int s = 0; s < RING; s++) begin
      q_status[k][s] = ST_EMPTY;
    end
    q_head[k] = '0;
    q_tail[k] = '0;
  endfunction

  // Applies one input word to the chosen view and returns the result word.
  function automatic out_item_t retry_queue_step(int k, in_item_t w);
    out_item_t r;
    logic [IW-1:0] h;
    logic [IW-1:0] t;
    logic [31:0] due;
    r = '0;
    h = q_head[k];
    t = q_tail[k];
    case (w.action)
      ACT_INSERT: begin
        if (q_status[k][t] != ST_EMPTY) begin
          // Tail slot still in use: the ring overflows.
          clear_ring(k);
          q_err[k] = 1'b1;
        end else begin
          q_err[k] = 1'b0;
          q_status[k][t] = ST_SCHED;
          q_cmd[k][t] = w.cmd_word;
          q_start[k][t] = '0;
          q_retries[k][t] = '0;
          q_tail[k] = ring_next(t);
        end
      end
      ACT_RESPONSE: begin
        if (q_status[k][h] != ST_EMPTY && w.cmd_word == (q_cmd[k][h] | cfg_confirm)) begin
          r.response_ok = 1'b1;
          q_status[k][h] = ST_EMPTY;
          q_head[k] = ring_next(h);
          if (q_status[k][q_head[k]] == ST_EMPTY) begin
            clear_ring(k);
          end
        end
      end
      ACT_POLL: begin
        if (q_status[k][h] == ST_SCHED) begin
          q_start[k][h] = w.now_time;
          q_retries[k][h] = '0;
          q_status[k][h] = ST_SENT;
          r.send_now = 1'b1;
          r.send_command = q_cmd[k][h];
          r.send_slot = 3'(h);
        end else if (q_status[k][h] == ST_SENT) begin
          due = q_start[k][h] + cfg_timeout;
          if (w.now_time > due) begin
            if (q_retries[k][h] > {1'b0, cfg_retry}) begin
              // Out of retries: give up on the whole ring.
              clear_ring(k);
              q_err[k] = 1'b1;
            end else begin
              q_retries[k][h] = q_retries[k][h] + 5'd1;
              q_start[k][h] = w.now_time;
              r.send_now = 1'b1;
              r.is_resend = 1'b1;
              r.send_command = q_cmd[k][h];
              r.send_slot = 3'(h);
            end
          end
        end else if (q_head[k] == q_tail[k] && q_head[k] != '0) begin
          clear_ring(k);
        end
      end
      default: begin
      end
    endcase
    r.error_flag = q_err[k];
    return r;
  endfunction

  // Queues one word for the driver and advances the planning view with it.
  function automatic void plan_word(logic [1:0] act, logic [15:0] word, logic [31:0] now);
    in_item_t w;
    w.action = act;
    w.cmd_word = word;
    w.now_time = now;
    void'(retry_queue_step(PLANNED_VIEW, w));
    pending_words.push_back(w);
    items_planned++;
  endfunction

  // Mostly well-formed traffic: inserts into free slots, matching responses to the
  // head and polls with a rising time, plus some noise and broken responses.
  function automatic void random_phase(int unsigned n, int unsigned answer_pct);
    logic [IW-1:0] h;
    logic [IW-1:0] t;
    logic [15:0] reply;
    logic [31:0] adv;
    int unsigned pick;
    for (int unsigned i = 0; i < n; i++) begin
      h = q_head[PLANNED_VIEW];
      t = q_tail[PLANNED_VIEW];
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        plan_word(2'($urandom_range(0, 3)), 16'($urandom), $urandom);
      end else if (pick < 40 &&
                   (q_status[PLANNED_VIEW][t] == ST_EMPTY || $urandom_range(0, 15) == 0)) begin
        plan_word(ACT_INSERT, 16'($urandom), $urandom);
      end else if (pick < 40 + answer_pct && q_status[PLANNED_VIEW][h] != ST_EMPTY) begin
        reply = q_cmd[PLANNED_VIEW][h] | cfg_confirm;
        if ($urandom_range(0, 7) == 0) begin
          reply = reply ^ 16'(1 << $urandom_range(0, 15));
        end
        plan_word(ACT_RESPONSE, reply, $urandom);
      end else begin
        if (cfg_timeout < 32'd100000) begin
          adv = $urandom_range(0, cfg_timeout + cfg_timeout / 2 + 2);
        end else begin
          adv = $urandom;
        end
        poll_clock = poll_clock + adv;
        plan_word(ACT_POLL, 16'($urandom), poll_clock);
      end
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // One register write: setup cycle, then access cycle.
  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // The register takes the value at this edge.
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_TIMEOUT: cfg_timeout = val;
      REG_RETRY: cfg_retry = val[3:0];
      REG_CONFIRM: cfg_confirm = val[15:0];
      default: begin
      end
    endcase
  endtask

  task automatic set_config(logic [31:0] timeout, logic [3:0] retry, logic [15:0] mask);
    cfg_write(REG_TIMEOUT, timeout);
    cfg_write(REG_RETRY, {28'd0, retry});
    cfg_write(REG_CONFIRM, {16'd0, mask});
  endtask

  // Holds the sender until every planned word is taken and every result is in.
  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (items_taken != items_planned || predicted_results.size() != 0);
  endtask

  // Driver: offers the next pending word, with random gaps unless feeding steadily.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predicted_results.push_back(retry_queue_step(ACCEPTED_VIEW, in_word));
        items_taken++;
      end
      if (!start || !busy) begin
        if (pending_words.size() != 0 && (steady_feed || $urandom_range(0, 99) >= 16)) begin
          start <= 1'b1;
          in_word <= pending_words.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result word is matched against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (predicted_results.size() == 0) begin
        $error("result word with nothing expected: 0x%0h", out_word);
        mismatches++;
      end else begin
        want = predicted_results.pop_front();
        check_field("send_now", 32'(want.send_now), 32'(out_word.send_now));
        check_field("send_command", 32'(want.send_command), 32'(out_word.send_command));
        check_field("send_slot", 32'(want.send_slot), 32'(out_word.send_slot));
        check_field("is_resend", 32'(want.is_resend), 32'(out_word.is_resend));
        check_field("response_ok", 32'(want.response_ok), 32'(out_word.response_ok));
        check_field("error_flag", 32'(want.error_flag), 32'(out_word.error_flag));
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("command_retry_queue_top: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    clear_ring(ACCEPTED_VIEW);
    clear_ring(PLANNED_VIEW);
    for (int k = 0; k < 2; k++) begin
      q_err[k] = 1'b0;
      for (int s = 0; s < RING; s++) begin
        q_cmd[k][s] = '0;
        q_start[k][s] = '0;
        q_retries[k][s] = '0;
      end
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset register values.
    // Poll and response on an empty ring, then the unused action code.
    plan_word(ACT_POLL, 16'h0000, 32'h0000_0000);
    plan_word(ACT_RESPONSE, 16'h0100, 32'h0000_0000);
    plan_word(ACT_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
    // A wrong response is ignored; the right one retires a head never sent.
    plan_word(ACT_INSERT, 16'hFFFF, 32'h0000_0000);
    plan_word(ACT_RESPONSE, 16'h0000, 32'h0000_0000);
    plan_word(ACT_RESPONSE, 16'hFFFF, 32'h0000_0000);
    // Send, wait exactly the timeout, then resend until the retries run out.
    plan_word(ACT_INSERT, 16'h0000, 32'h0000_0000);
    plan_word(ACT_INSERT, 16'h1234, 32'h0000_0000);
    plan_word(ACT_POLL, 16'h0000, 32'd0);
    plan_word(ACT_POLL, 16'h0000, 32'd1000);
    plan_word(ACT_POLL, 16'h0000, 32'd1001);
    plan_word(ACT_POLL, 16'h0000, 32'd2002);
    plan_word(ACT_POLL, 16'h0000, 32'd3003);
    plan_word(ACT_POLL, 16'h0000, 32'd4004);
    plan_word(ACT_POLL, 16'h0000, 32'd5005);
    // A good insert clears the error; filling the ring and one more overflows it.
    plan_word(ACT_INSERT, 16'hA5A5, 32'h0000_0000);
    for (int i = 0; i < RING - 1; i++) begin
      plan_word(ACT_INSERT, 16'($urandom), $urandom);
    end
    plan_word(ACT_INSERT, 16'h5A5A, 32'h0000_0000);
    poll_clock = 32'd5005;
    wait_drained();

    // Random phases over several register settings: the reset values, then the extremes.
    set_config(TIMEOUT_RST, RETRY_RST, CONFIRM_RST);
    random_phase(290, 30);
    wait_drained();

    set_config(32'd0, 4'd0, 16'h0000);
    random_phase(290, 30);
    wait_drained();

    set_config(32'hFFFF_FFFF, 4'd15, 16'hFFFF);
    random_phase(290, 25);
    wait_drained();

    // Short timeout and few responses, so the retries run out at the top limit.
    set_config(32'd60, 4'd15, 16'h8001);
    random_phase(290, 5);
    wait_drained();

    // A stretch with the sender never pausing.
    set_config($urandom_range(0, 5000), 4'($urandom_range(0, 15)), 16'($urandom));
    steady_feed = 1'b1;
    random_phase(290, 35);
    wait_drained();
    steady_feed = 1'b0;

    set_config($urandom, 4'($urandom_range(0, 15)), 16'($urandom));
    random_phase(290, 30);
    wait_drained();

    // Allow for a stray late result before the verdict.
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("command_retry_queue_top: match");
    end else begin
      $display("command_retry_queue_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
+incdir+rtl
rtl/crq_pkg.sv
rtl/crq_cfg_regs.sv
rtl/crq_slot_queue.sv
rtl/command_retry_queue_top.sv
tb/tb_command_retry_queue_top.sv
